// ===== rtl/animation_easing_progress_defines.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ANIMATION_EASING_PROGRESS_DEFINES_SVH
`define ANIMATION_EASING_PROGRESS_DEFINES_SVH
// implication checked on every clock edge outside reset
`define AEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define AEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/aep_pkg.sv =====
// package for the easing progress block: widths, curve codes, cell payload
// no dependencies
package aep_pkg;
    localparam int FracBits = 16;
    localparam int TimeBits = 32;
    localparam int ProgBits = FracBits + 1;
    localparam int ModeBits = 3;
    localparam int SmNumBits = 2 + 2 * FracBits;  // 3*p*ONE
    localparam int SmDenBits = FracBits + 2;      // p + 2*ONE
    localparam int SmQBits = FracBits + 2;
    localparam int QSteps = ProgBits + 1;
    localparam logic [ProgBits-1:0] OneQ = ProgBits'(1) << FracBits;
    localparam logic [ProgBits-1:0] HalfQ = ProgBits'(1) << (FracBits - 1);

    localparam logic [ModeBits-1:0] ModeLinear = 3'd0;
    localparam logic [ModeBits-1:0] ModeSlow = 3'd1;
    localparam logic [ModeBits-1:0] ModeFast = 3'd2;
    localparam logic [ModeBits-1:0] ModeStep = 3'd3;
    localparam logic [ModeBits-1:0] ModeSmooth = 3'd4;

    // restoring divider cell payload, one quotient bit per cell
    typedef struct packed {
        logic                 vld;
        logic [TimeBits:0]    rem;
        logic [TimeBits-1:0]  den;
        logic [FracBits-1:0]  quo;
        logic                 sat;
        logic [ModeBits-1:0]  mode;
    } t_lin;

    typedef struct packed {
        logic                 vld;
        logic [SmNumBits-1:0] num;
        logic [SmDenBits:0]   rem;
        logic [SmDenBits-1:0] den;
        logic [SmNumBits-1:0] quo;
    } t_div;
endpackage

// ===== rtl/aep_lin_cell.sv =====
// one restoring division step for linear progress
// depends on aep_pkg
module aep_lin_cell import aep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_lin i_d,
    output t_lin o_d
);
    t_lin r_d, n_d;
    logic [TimeBits+1:0] w_sh;

    // shift remainder, compare against duration
    always_comb begin
        n_d = i_d;
        w_sh = {i_d.rem, 1'b0};
        n_d.quo = {i_d.quo[FracBits-2:0], 1'b0};
        n_d.rem = w_sh[TimeBits:0];
        if (w_sh >= {2'b00, i_d.den}) begin
            n_d.rem = (TimeBits+1)'(w_sh - {2'b00, i_d.den});
            n_d.quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
        r_d.rem <= n_d.rem;
        r_d.den <= n_d.den;
        r_d.quo <= n_d.quo;
        r_d.sat <= n_d.sat;
        r_d.mode <= n_d.mode;
    end
    assign o_d = r_d;
endmodule

// ===== rtl/aep_div_cell.sv =====
// one restoring division step for the smooth curve divisions
// depends on aep_pkg
module aep_div_cell import aep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_div i_d,
    output t_div o_d
);
    t_div r_d, n_d;
    logic [SmDenBits+1:0] w_sh;

    // bring in next numerator bit, subtract if it fits
    always_comb begin
        n_d = i_d;
        w_sh = {i_d.rem, i_d.num[SmNumBits-1]};
        n_d.num = {i_d.num[SmNumBits-2:0], 1'b0};
        n_d.quo = {i_d.quo[SmNumBits-2:0], 1'b0};
        n_d.rem = w_sh[SmDenBits:0];
        if (w_sh >= {2'b00, i_d.den}) begin
            n_d.rem = (SmDenBits+1)'(w_sh - {2'b00, i_d.den});
            n_d.quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
        r_d.num <= n_d.num;
        r_d.rem <= n_d.rem;
        r_d.den <= n_d.den;
        r_d.quo <= n_d.quo;
    end
    assign o_d = r_d;
endmodule

// ===== rtl/animation_easing_progress.sv =====
// easing progress top level: divider cell chains, curve multiplier stages
// depends on aep_pkg, aep_lin_cell, aep_div_cell
//
//  channel  | handshake           | fields
//  input    | i_start / o_busy    | i_elapsed_ms, i_duration_ms, i_curve_mode
//  result   | o_strobe            | o_progress, o_done_res
//
// one transaction per cycle; o_busy is always low
// a result strobes after passing through 16 linear cells, two
// curve stages, 34 + 1 + 34 smooth division stages and the output register;
// every curve takes this same path, its length set by the smooth chain
// synchronous active-low reset clears all valid bits
// the receiver cannot stall, results come out in input order
module animation_easing_progress import aep_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [TimeBits-1:0] i_elapsed_ms,
    input  logic [TimeBits-1:0] i_duration_ms,
    input  logic [ModeBits-1:0] i_curve_mode,
    output logic                o_strobe,
    output logic [ProgBits-1:0] o_progress,
    output logic                o_done_res
);
    localparam int NDiv = SmNumBits;
    localparam int Lat = 2 * NDiv + 4;  // stages after linear progress
    localparam int PW = 2 * ProgBits;

    assign o_busy = 1'b0;

    // linear division chain
    t_lin w_lin [FracBits+1];
    always_comb begin
        w_lin[0].vld = i_start;
        w_lin[0].rem = {1'b0, i_elapsed_ms};
        w_lin[0].den = i_duration_ms;
        w_lin[0].quo = '0;
        w_lin[0].sat = (i_duration_ms == '0) || (i_elapsed_ms >= i_duration_ms);
        w_lin[0].mode = i_curve_mode;
    end
    for (genvar g = 0; g < FracBits; g++) begin : g_lin
        aep_lin_cell u_cell (.i_clk, .i_rst_n, .i_d(w_lin[g]), .o_d(w_lin[g+1]));
    end

    logic [ProgBits-1:0] w_p;
    assign w_p = w_lin[FracBits].sat ? OneQ : {1'b0, w_lin[FracBits].quo};

    // stage a: register p and t = ONE - p
    logic                r_a_vld;
    logic [ModeBits-1:0] r_a_mode;
    logic [ProgBits-1:0] r_a_p, r_a_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else r_a_vld <= w_lin[FracBits].vld;
        r_a_mode <= w_lin[FracBits].mode;
        r_a_p <= w_p;
        r_a_t <= OneQ - w_p;
    end

    // stage b: square of p and of t
    logic [ProgBits-1:0] r_b_p, r_b_t, r_b_pp, r_b_tt;
    logic [ModeBits-1:0] r_b_mode;
    logic                r_b_vld;
    logic [PW-1:0]       w_pp, w_tt;
    assign w_pp = {{ProgBits{1'b0}}, r_a_p} * {{ProgBits{1'b0}}, r_a_p};
    assign w_tt = {{ProgBits{1'b0}}, r_a_t} * {{ProgBits{1'b0}}, r_a_t};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else r_b_vld <= r_a_vld;
        r_b_mode <= r_a_mode;
        r_b_p <= r_a_p;
        r_b_t <= r_a_t;
        r_b_pp <= ProgBits'(w_pp >> FracBits);
        r_b_tt <= ProgBits'(w_tt >> FracBits);
    end

    // stage c: cubic and smoothstep products
    logic [PW+1:0]       w_p3, w_t3, w_ss;
    logic [ProgBits+1:0] w_lin3;
    logic [ProgBits-1:0] w_cres;
    assign w_lin3 = (ProgBits+2)'(3 * OneQ) - {r_b_p, 1'b0};
    assign w_p3 = (PW+2)'(r_b_pp) * (PW+2)'(r_b_p);
    assign w_t3 = (PW+2)'(r_b_tt) * (PW+2)'(r_b_t);
    assign w_ss = (PW+2)'(r_b_pp) * (PW+2)'(w_lin3);
    always_comb begin
        logic [PW+1:0] v;
        case (r_b_mode)
            ModeSlow:  v = (PW+2)'(OneQ) - (w_t3 >> FracBits);
            ModeFast:  v = w_p3 >> FracBits;
            ModeStep:  v = w_ss >> FracBits;
            default:   v = (PW+2)'(r_b_p);
        endcase
        w_cres = (v > (PW+2)'(OneQ)) ? OneQ : ProgBits'(v);
    end

    // first smooth division: 3*p*ONE / (p + 2*ONE)
    t_div w_d1 [NDiv+1];
    always_comb begin
        w_d1[0].vld = r_b_vld;
        w_d1[0].num = SmNumBits'({r_b_p, {(FracBits+1){1'b0}}}) +
                      SmNumBits'({r_b_p, {FracBits{1'b0}}});
        w_d1[0].rem = '0;
        w_d1[0].den = SmDenBits'(r_b_p) + SmDenBits'(2 * OneQ);
        w_d1[0].quo = '0;
    end
    for (genvar g = 0; g < NDiv; g++) begin : g_d1
        aep_div_cell u_cell (.i_clk, .i_rst_n, .i_d(w_d1[g]), .o_d(w_d1[g+1]));
    end

    // stage e: fold r into a, square for second denominator
    logic [SmNumBits-1:0] w_r;
    logic [SmNumBits:0]   w_tw;
    logic                 w_neg;
    logic [SmNumBits:0]   w_a;
    logic                 r_e_neg, r_e_big;
    logic [ProgBits-1:0]  r_e_a;
    logic [SmDenBits-1:0] w_den2;
    logic [PW-1:0]        w_aa;
    assign w_r = w_d1[NDiv].quo;
    assign w_tw = {w_r, 1'b0};
    assign w_neg = w_tw < (SmNumBits+1)'(OneQ);
    assign w_a = w_neg ? (SmNumBits+1)'(OneQ) - w_tw : w_tw - (SmNumBits+1)'(OneQ);
    always_ff @(posedge i_clk) begin
        r_e_neg <= w_neg;
        r_e_big <= w_a >= (SmNumBits+1)'(OneQ);
        r_e_a <= ProgBits'(w_a);
    end
    assign w_aa = {{ProgBits{1'b0}}, r_e_a} * {{ProgBits{1'b0}}, r_e_a};
    assign w_den2 = SmDenBits'(OneQ) + SmDenBits'(w_aa >> FracBits);

    // second smooth division, (a << F) / den, with side info in a delay line
    logic r_e_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else r_e_vld <= w_d1[NDiv].vld;
    end
    t_div w_d2 [NDiv+1];
    always_comb begin
        w_d2[0].vld = r_e_vld;
        w_d2[0].num = SmNumBits'({r_e_a, {FracBits{1'b0}}});
        w_d2[0].rem = '0;
        w_d2[0].den = w_den2;
        w_d2[0].quo = '0;
    end
    for (genvar g = 0; g < NDiv; g++) begin : g_d2
        aep_div_cell u_cell (.i_clk, .i_rst_n, .i_d(w_d2[g]), .o_d(w_d2[g+1]));
    end
    logic r_sg_neg [NDiv+1];
    logic r_sg_big [NDiv+1];
    assign r_sg_neg[0] = r_e_neg;
    assign r_sg_big[0] = r_e_big;
    for (genvar g = 0; g < NDiv; g++) begin : g_sg
        always_ff @(posedge i_clk) begin
            r_sg_neg[g+1] <= r_sg_neg[g];
            r_sg_big[g+1] <= r_sg_big[g];
        end
    end

    // smooth result
    logic [SmNumBits-1:0] w_q;
    logic [SmNumBits:0]   w_sm0;
    logic [ProgBits-1:0]  w_sm;
    assign w_q = w_d2[NDiv].quo;
    always_comb begin
        w_sm0 = '0;
        if (r_sg_big[NDiv]) begin
            w_sm0 = r_sg_neg[NDiv] ? '0 : (SmNumBits+1)'(OneQ);
        end else if (r_sg_neg[NDiv]) begin
            w_sm0 = (w_q >= SmNumBits'(HalfQ)) ? '0 :
                    (SmNumBits+1)'(HalfQ) - (SmNumBits+1)'(w_q);
        end else begin
            w_sm0 = (SmNumBits+1)'(HalfQ) + (SmNumBits+1)'(w_q);
        end
        w_sm = (w_sm0 > (SmNumBits+1)'(OneQ)) ? OneQ : ProgBits'(w_sm0);
    end

    // delay line for the non-smooth result and mode
    logic [ProgBits-1:0] r_dl_res [Lat-3];
    logic                r_dl_sm [Lat-3];
    logic [ProgBits-1:0] w_dl_in;
    assign w_dl_in = w_cres;
    always_ff @(posedge i_clk) begin
        r_dl_res[0] <= w_dl_in;
        r_dl_sm[0] <= (r_b_mode == ModeSmooth);
    end
    for (genvar g = 1; g < Lat - 3; g++) begin : g_dl
        always_ff @(posedge i_clk) begin
            r_dl_res[g] <= r_dl_res[g-1];
            r_dl_sm[g] <= r_dl_sm[g-1];
        end
    end

    // output register
    logic                r_o_vld;
    logic [ProgBits-1:0] r_o_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else r_o_vld <= w_d2[NDiv].vld;
        r_o_res <= r_dl_sm[Lat-4] ? w_sm : r_dl_res[Lat-4];
    end

    assign o_strobe = r_o_vld;
    assign o_progress = r_o_res;
    assign o_done_res = (r_o_res == OneQ);
endmodule

// ===== rtl/aep_checker.sv =====
// port-level checks for the easing progress block
// depends on aep_pkg and animation_easing_progress_defines.svh
`include "animation_easing_progress_defines.svh"
module aep_checker import aep_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_busy,
    input logic                o_strobe,
    input logic [ProgBits-1:0] o_progress,
    input logic                o_done_res
);
    `AEP_ASSERT_IMPL(a_done, i_clk, i_rst_n, o_strobe, o_done_res == (o_progress == OneQ))
    `AEP_ASSERT_IMPL(a_range, i_clk, i_rst_n, o_strobe, o_progress <= OneQ)
    `AEP_ASSERT_IMPL(a_nobusy, i_clk, i_rst_n, 1'b1, !o_busy)
    `AEP_ASSERT_NEXT(a_rst, i_clk, 1'b1, !i_rst_n, !o_strobe)
endmodule

bind animation_easing_progress aep_checker u_aep_checker (
    .i_clk, .i_rst_n, .o_busy, .o_strobe, .o_progress, .o_done_res
);
